/* design/assert_macros.svh */
// Shared assertion macros. All three expect i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that a condition holds in the cycle after the trigger.
`define ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

// Check that a condition holds in the same cycle as the trigger.
`define ASSERT_IMPL(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

/* design/fcsc_pkg.sv */
package fcsc_pkg;

    localparam int TEMP_W   = 12;
    localparam int TW       = 13;   // threshold math, covers every band sum
    localparam int TIME_W   = 32;
    localparam int DWELL_W  = 16;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int SP_SCALE = 10;

    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_HEAT = 2'd1;
    localparam logic [1:0] MODE_COOL = 2'd2;

    typedef logic [1:0] t_level;

    typedef enum logic [2:0] {
        REG_MODE      = 3'd0,
        REG_SETPOINT  = 3'd1,
        REG_LOW_BAND  = 3'd2,
        REG_HIGH_BAND = 3'd3,
        REG_STEP_DOWN = 3'd4,
        REG_MIN_DWELL = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]         reg_mode;
        logic [5:0]         setpoint_deg;
        logic [7:0]         low_band;
        logic [7:0]         high_band;
        logic [7:0]         step_down_diff;
        logic [DWELL_W-1:0] min_dwell_ms;
    } t_cfg;

    typedef struct packed {
        t_level     target;
        t_level     applied;
        logic [2:0] relays;     // {high, mid, low}
    } t_result;

    function automatic logic [2:0] relay_of(input t_level lv);
        logic [2:0] r;
        unique case (lv)
            2'd1:    r = 3'b001;
            2'd2:    r = 3'b010;
            2'd3:    r = 3'b100;
            default: r = 3'b000;
        endcase
        return r;
    endfunction

endpackage

/* design/fcsc_regs.sv */
module fcsc_regs
    import fcsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite & pready;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reg_mode       <= MODE_OFF;
            r_cfg.setpoint_deg   <= 6'd15;
            r_cfg.low_band       <= 8'd1;
            r_cfg.high_band      <= 8'd2;
            r_cfg.step_down_diff <= 8'd1;
            r_cfg.min_dwell_ms   <= 16'd1000;
        end else if (wr_en) begin
            unique case (idx)
                REG_MODE:      r_cfg.reg_mode       <= pwdata[1:0];
                REG_SETPOINT:  r_cfg.setpoint_deg   <= pwdata[5:0];
                REG_LOW_BAND:  r_cfg.low_band       <= pwdata[7:0];
                REG_HIGH_BAND: r_cfg.high_band      <= pwdata[7:0];
                REG_STEP_DOWN: r_cfg.step_down_diff <= pwdata[7:0];
                REG_MIN_DWELL: r_cfg.min_dwell_ms   <= pwdata[DWELL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MODE:      prdata = DATA_W'(r_cfg.reg_mode);
            REG_SETPOINT:  prdata = DATA_W'(r_cfg.setpoint_deg);
            REG_LOW_BAND:  prdata = DATA_W'(r_cfg.low_band);
            REG_HIGH_BAND: prdata = DATA_W'(r_cfg.high_band);
            REG_STEP_DOWN: prdata = DATA_W'(r_cfg.step_down_diff);
            REG_MIN_DWELL: prdata = DATA_W'(r_cfg.min_dwell_ms);
            default:       prdata = '0;
        endcase
    end

endmodule

/* design/fcsc_hyst.sv */
module fcsc_hyst
    import fcsc_pkg::*;
(
    input  t_cfg               i_cfg,
    input  logic signed [TEMP_W-1:0] i_temp,
    input  t_level             i_level,
    output t_level             o_level
);

    logic signed [TW-1:0] t, sp, lo, hi, df;
    t_level cool_lv, heat_lv;

    assign t  = TW'(i_temp);
    assign sp = $signed(TW'(i_cfg.setpoint_deg) * TW'(SP_SCALE));
    assign lo = $signed(TW'(i_cfg.low_band));
    assign hi = $signed(TW'(i_cfg.high_band));
    assign df = $signed(TW'(i_cfg.step_down_diff));

    // Cooling: step up as temperature climbs above the setpoint.
    always_comb begin
        cool_lv = i_level;
        case (i_level)
            2'd0: if (t > sp + lo) cool_lv = 2'd1;
            2'd1: begin
                if (t > sp + hi)  cool_lv = 2'd2;
                else if (t <= sp) cool_lv = 2'd0;
            end
            2'd2: begin
                if (t > sp + hi + lo)       cool_lv = 2'd3;
                else if (t <= sp + hi - df) cool_lv = 2'd1;
            end
            default: if (t <= sp + hi + lo - df) cool_lv = 2'd2;
        endcase
    end

    // Heating: mirror image below the setpoint.
    always_comb begin
        heat_lv = i_level;
        case (i_level)
            2'd0: if (t < sp - lo) heat_lv = 2'd1;
            2'd1: begin
                if (t < sp - hi)  heat_lv = 2'd2;
                else if (t >= sp) heat_lv = 2'd0;
            end
            2'd2: begin
                if (t < sp - hi - lo)       heat_lv = 2'd3;
                else if (t >= sp - hi + df) heat_lv = 2'd1;
            end
            default: if (t >= sp - hi - lo + df) heat_lv = 2'd2;
        endcase
    end

    always_comb begin
        case (i_cfg.reg_mode)
            MODE_OFF:  o_level = 2'd0;
            MODE_HEAT: o_level = heat_lv;
            MODE_COOL: o_level = cool_lv;
            default:   o_level = i_level;   // active but no direction: hold
        endcase
    end

endmodule

/* design/fcsc_seq.sv */
`include "assert_macros.svh"

module fcsc_seq
    import fcsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_mode_off,
    input  logic [TIME_W-1:0]  i_now_ms,
    input  logic [DWELL_W-1:0] i_dwell_ms,
    input  t_level             i_next_target,
    output t_level             o_target,
    output t_result            o_next
);

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_OFF_DONE = 2'd1,
        PH_ON_DONE  = 2'd2
    } t_phase;

    t_phase              r_phase, n_phase, phase_t;
    t_level              r_target, r_applied, n_applied;
    logic [2:0]          r_relays, n_relays;
    logic [TIME_W-1:0]   r_stamp, n_stamp, elapsed;
    logic                due;

    always_comb begin
        phase_t   = i_mode_off ? PH_IDLE : r_phase;
        n_phase   = phase_t;
        n_applied = r_applied;
        n_relays  = r_relays;
        n_stamp   = r_stamp;
        elapsed   = i_now_ms - r_stamp;
        due       = (i_next_target != r_applied) && (elapsed >= TIME_W'(i_dwell_ms));
        if (due) begin
            if (phase_t == PH_OFF_DONE) begin
                // second phase: close the relay of the new speed
                if (i_next_target != 2'd0) begin
                    n_relays = r_relays | relay_of(i_next_target);
                    n_stamp  = i_now_ms;
                end
                n_applied = i_next_target;
                n_phase   = PH_ON_DONE;
            end else begin
                // first phase: drop all relays
                n_relays = 3'b000;
                if (r_applied != 2'd0) n_stamp = i_now_ms;
                n_phase = PH_OFF_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_target  <= 2'd0;
            r_applied <= 2'd0;
            r_relays  <= 3'b000;
            r_stamp   <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_target  <= i_next_target;
            r_applied <= n_applied;
            r_relays  <= n_relays;
            r_stamp   <= n_stamp;
        end
    end

    assign o_target       = r_target;
    assign o_next.target  = i_next_target;
    assign o_next.applied = n_applied;
    assign o_next.relays  = n_relays;

    `ASSERT_ALWAYS(a_relay_excl, $onehot0(r_relays), "more than one relay closed")
    `ASSERT_IMPL(a_relay_applied, r_relays != 3'b000, r_relays == relay_of(r_applied), "closed relay does not match applied speed")
    `ASSERT_NEXT(a_hold_idle, !i_step, $stable(r_stamp) && $stable(r_applied) && $stable(r_relays), "state moved without a request")

endmodule

/* design/fancoil_three_speed_controller.sv */
// Three-speed fan-coil controller.
// Input channel (i_valid / o_stall): one request per service call, carrying
// the measured temperature in tenths of a degree and the millisecond tick.
// Output channel (o_valid / i_stall): one result per request, giving target
// and applied speed and the three exclusive relay drives.
// Configuration: APB-style port with pready tied high, registers at 4*index;
// the user must write them only while no request is in flight (unenforced).
// Result path: o_valid rises when the hysteresis and switch sequencer have
// settled the request held in the input register into the result register.
// Throughput: one request per cycle while i_stall is low; the only loop is the
// registered update of target, applied speed, phase, dwell stamp and relays.
// Stall: while the result register is full and i_stall is high, the result
// holds and the input register holds its request; o_stall rises only when
// both stages are occupied.
// Reset (synchronous, active low): both stages empty, speeds 0, relays off,
// dwell stamp 0, registers at their defaults.
module fancoil_three_speed_controller
    import fcsc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [TEMP_W-1:0] i_measured_temp,
    input  logic [TIME_W-1:0]        i_now_ms,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [1:0]               o_target_speed,
    output logic [1:0]               o_applied_speed,
    output logic                     o_relay_low,
    output logic                     o_relay_mid,
    output logic                     o_relay_high,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    t_cfg    cfg;
    t_level  cur_target, next_target;
    t_result next_res;

    logic                     r_in_valid, r_out_valid;
    logic signed [TEMP_W-1:0] r_temp;
    logic [TIME_W-1:0]        r_now;
    t_result                  r_res;
    logic                     in_acc, advance;

    // Advance the held request whenever the result register is free or
    // being drained this cycle.
    assign advance = r_in_valid & (~r_out_valid | ~i_stall);
    assign o_stall = r_in_valid & r_out_valid & i_stall;
    assign in_acc  = i_valid & ~o_stall;

    fcsc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fcsc_hyst u_hyst (
        .i_cfg   (cfg),
        .i_temp  (r_temp),
        .i_level (cur_target),
        .o_level (next_target)
    );

    fcsc_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_mode_off    (cfg.reg_mode == MODE_OFF),
        .i_now_ms      (r_now),
        .i_dwell_ms    (cfg.min_dwell_ms),
        .i_next_target (next_target),
        .o_target      (cur_target),
        .o_next        (next_res)
    );

    // Stage occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: load on acceptance, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_temp <= i_measured_temp;
            r_now  <= i_now_ms;
        end
        if (advance) begin
            r_res <= next_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_target_speed  = r_res.target;
    assign o_applied_speed = r_res.applied;
    assign o_relay_low     = r_res.relays[0];
    assign o_relay_mid     = r_res.relays[1];
    assign o_relay_high    = r_res.relays[2];

endmodule

/* bench/fancoil_speed_checker.sv */
`timescale 1ns / 1ps

module fancoil_speed_checker
    import fcsc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic                     o_stall,
    input  logic signed [TEMP_W-1:0] i_measured_temp,
    input  logic [TIME_W-1:0]        i_now_ms,
    input  logic                     o_valid,
    input  logic                     i_stall,
    input  logic [1:0]               o_target_speed,
    input  logic [1:0]               o_applied_speed,
    input  logic                     o_relay_low,
    input  logic                     o_relay_mid,
    input  logic                     o_relay_high,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output int                       fail_count,
    output int                       pending
);

    t_cfg              cfg;
    t_level            tgt_lv;
    t_level            app_lv;
    logic [1:0]        phase;
    logic [TIME_W-1:0] stamp;
    logic [2:0]        relays;
    t_result           expected_speeds[$];
    t_result           got;
    t_result           want;

    function automatic t_level cool_stage(input t_level lv, input int t, input int sp,
                                          input int lo, input int hi, input int df);
        if (lv == 2'd0 && t > sp + lo) return 2'd1;
        if (lv == 2'd1 && t > sp + hi) return 2'd2;
        if (lv == 2'd1 && t <= sp) return 2'd0;
        if (lv == 2'd2 && t > sp + hi + lo) return 2'd3;
        if (lv == 2'd2 && t <= sp + hi - df) return 2'd1;
        if (lv == 2'd3 && t <= sp + hi + lo - df) return 2'd2;
        return lv;
    endfunction

    function automatic t_level heat_stage(input t_level lv, input int t, input int sp,
                                          input int lo, input int hi, input int df);
        if (lv == 2'd0 && t < sp - lo) return 2'd1;
        if (lv == 2'd1 && t < sp - hi) return 2'd2;
        if (lv == 2'd1 && t >= sp) return 2'd0;
        if (lv == 2'd2 && t < sp - hi - lo) return 2'd3;
        if (lv == 2'd2 && t >= sp - hi + df) return 2'd1;
        if (lv == 2'd3 && t >= sp - hi - lo + df) return 2'd2;
        return lv;
    endfunction

    // Update the stage and relay sequence for one request, queue its result.
    task automatic predict_call(input logic signed [TEMP_W-1:0] temp,
                                input logic [TIME_W-1:0] now);
        int                t;
        int                sp;
        logic [TIME_W-1:0] elapsed;
        t_result           r;
        t = temp;
        sp = int'(cfg.setpoint_deg) * SP_SCALE;
        if (cfg.reg_mode == MODE_OFF) begin
            phase = 2'd0;
            tgt_lv = 2'd0;
        end else if (cfg.reg_mode == MODE_COOL) begin
            tgt_lv = cool_stage(tgt_lv, t, sp, int'(cfg.low_band), int'(cfg.high_band),
                                int'(cfg.step_down_diff));
        end else if (cfg.reg_mode == MODE_HEAT) begin
            tgt_lv = heat_stage(tgt_lv, t, sp, int'(cfg.low_band), int'(cfg.high_band),
                                int'(cfg.step_down_diff));
        end
        elapsed = now - stamp;
        if (tgt_lv != app_lv && elapsed >= TIME_W'(cfg.min_dwell_ms)) begin
            if (phase > 2'd1) phase = 2'd0;
            if (phase == 2'd0) begin
                relays = 3'b000;
                if (app_lv != 2'd0) stamp = now;
                phase = 2'd1;
            end else begin
                if (tgt_lv != 2'd0) begin
                    relays = relays | (3'b001 << (tgt_lv - 2'd1));
                    stamp = now;
                end
                app_lv = tgt_lv;
                phase = 2'd2;
            end
        end
        r.target = tgt_lv;
        r.applied = app_lv;
        r.relays = relays;
        expected_speeds.push_back(r);
    endtask

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t speed check failed (%s): expected target %0d applied %0d relays %b,",
                     $realtime, what, want.target, want.applied, want.relays,
                     " got target %0d applied %0d relays %b",
                     got.target, got.applied, got.relays);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.reg_mode = MODE_OFF;
            cfg.setpoint_deg = 6'd15;
            cfg.low_band = 8'd1;
            cfg.high_band = 8'd2;
            cfg.step_down_diff = 8'd1;
            cfg.min_dwell_ms = 16'd1000;
            tgt_lv = 2'd0;
            app_lv = 2'd0;
            phase = 2'd0;
            stamp = '0;
            relays = 3'b000;
            expected_speeds.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[ADDR_W-1:2]))
                    REG_MODE:      cfg.reg_mode = pwdata[1:0];
                    REG_SETPOINT:  cfg.setpoint_deg = pwdata[5:0];
                    REG_LOW_BAND:  cfg.low_band = pwdata[7:0];
                    REG_HIGH_BAND: cfg.high_band = pwdata[7:0];
                    REG_STEP_DOWN: cfg.step_down_diff = pwdata[7:0];
                    REG_MIN_DWELL: cfg.min_dwell_ms = pwdata[DWELL_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall)
                predict_call(i_measured_temp, i_now_ms);
            if (o_valid && !i_stall) begin
                got = {o_target_speed, o_applied_speed, o_relay_high, o_relay_mid, o_relay_low};
                if (expected_speeds.size() == 0) begin
                    want = 'x;
                    note_failure("no request waiting");
                end else begin
                    want = expected_speeds.pop_front();
                    if (got.target !== want.target || got.applied !== want.applied ||
                        got.relays !== want.relays)
                        note_failure("field differs");
                end
            end
        end
        pending = expected_speeds.size();
    end

endmodule

/* bench/fancoil_three_speed_controller_tb.sv */
`timescale 1ns / 1ps

module fancoil_three_speed_controller_tb;
    import fcsc_pkg::*;

    // Mode value that counts as active but selects neither heating nor cooling.
    localparam logic [1:0] MODE_HOLD = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 12;
    localparam int CALLS_PER_PHASE = 104;

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic signed [TEMP_W-1:0] i_measured_temp = '0;
    logic [TIME_W-1:0]        i_now_ms = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [1:0]               o_target_speed;
    logic [1:0]               o_applied_speed;
    logic                     o_relay_low;
    logic                     o_relay_mid;
    logic                     o_relay_high;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    int fail_count;
    int pending;

    // Stimulus shaping: a copy of the settings last written, the running
    // millisecond tick and a wandering temperature.
    int                cur_sp10 = 150;
    int                cur_lo = 1;
    int                cur_hi = 2;
    int                cur_df = 1;
    logic [DWELL_W-1:0] cur_dwell = 16'd1000;
    logic [TIME_W-1:0] tick = '0;
    int                temp_walk = 0;
    int                stall_run = 0;
    int                cycles = 0;
    bit                quiet = 1'b0;
    bit                stall_en = 1'b1;
    bit                gap_en = 1'b1;

    fancoil_three_speed_controller u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_measured_temp (i_measured_temp),
        .i_now_ms        (i_now_ms),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_target_speed  (o_target_speed),
        .o_applied_speed (o_applied_speed),
        .o_relay_low     (o_relay_low),
        .o_relay_mid     (o_relay_mid),
        .o_relay_high    (o_relay_high),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    fancoil_speed_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_measured_temp (i_measured_temp),
        .i_now_ms        (i_now_ms),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_target_speed  (o_target_speed),
        .o_applied_speed (o_applied_speed),
        .o_relay_low     (o_relay_low),
        .o_relay_mid     (o_relay_mid),
        .o_relay_high    (o_relay_high),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hang guard: end the run if the block stops answering.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side back-pressure: random stall bursts, dropped entirely in phases
    // with stall_en off and in the quiet closing phase.
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet || !stall_en) begin
            i_stall <= 1'b0;
        end else if (stall_run > 0) begin
            i_stall <= 1'b1;
            stall_run--;
        end else if ($urandom_range(0, 4) == 0) begin
            i_stall <= 1'b1;
            stall_run = $urandom_range(0, 5);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Offer one request; optionally idle a burst first. Valid stays high
    // straight into the next request when no gap is taken, so it is never
    // lowered and raised within one step. Returns at the accepting edge.
    task automatic send_call(input logic signed [TEMP_W-1:0] temp,
                             input logic [TIME_W-1:0] now);
        if (gap_en && !quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_measured_temp <= temp;
        i_now_ms <= now;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Drop valid and hold until every request has its result, then let the
    // pipeline settle before touching the registers.
    task automatic drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup phase, access phase until pready, then an idle phase so
    // that the next write starts in a fresh step.
    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [1:0] mode, input logic [5:0] sp,
                                  input logic [7:0] lo, input logic [7:0] hi,
                                  input logic [7:0] df, input logic [DWELL_W-1:0] dwell);
        drain();
        write_reg(REG_MODE, DATA_W'(mode));
        write_reg(REG_SETPOINT, DATA_W'(sp));
        write_reg(REG_LOW_BAND, DATA_W'(lo));
        write_reg(REG_HIGH_BAND, DATA_W'(hi));
        write_reg(REG_STEP_DOWN, DATA_W'(df));
        write_reg(REG_MIN_DWELL, DATA_W'(dwell));
        cur_sp10 = int'(sp) * SP_SCALE;
        cur_lo = int'(lo);
        cur_hi = int'(hi);
        cur_df = int'(df);
        cur_dwell = dwell;
    endtask

    // Mostly narrow bands so that all three stages get reached; now and
    // then a wide one.
    function automatic logic [7:0] pick_band();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 12));
    endfunction

    // Short dwell keeps the relay sequence busy; a few long ones test waiting.
    function automatic logic [DWELL_W-1:0] pick_dwell();
        if ($urandom_range(0, 4) == 0) return DWELL_W'($urandom_range(0, 65535));
        return DWELL_W'($urandom_range(0, 40));
    endfunction

    // Advance the tick: often short of the dwell, often just past it,
    // sometimes not at all, sometimes a jump anywhere (wrap included).
    function automatic logic [TIME_W-1:0] next_tick(input logic [TIME_W-1:0] t,
                                                    input logic [DWELL_W-1:0] dwell);
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return t + TIME_W'($urandom_range(0, int'(dwell) / 2));
        if (r < 8) return t + TIME_W'(dwell) + TIME_W'($urandom_range(0, 20));
        if (r == 8) return t;
        return TIME_W'($urandom);
    endfunction

    // Walk the temperature around the setpoint across every threshold, with
    // occasional jumps inside the band window and across the full field.
    function automatic int next_temp(input int prev);
        int win;
        int stepmax;
        int r;
        int t;
        win = cur_lo + cur_hi + cur_df + 4;
        stepmax = win / 6 + 1;
        r = $urandom_range(0, 9);
        t = prev;
        if (r < 7) begin
            t = prev + $urandom_range(0, 2 * stepmax) - stepmax;
            if (t > cur_sp10 + win + 10 || t < cur_sp10 - win - 10) t = cur_sp10;
        end else if (r < 9) begin
            t = cur_sp10 - win + $urandom_range(0, 2 * win);
        end else begin
            t = $signed(TEMP_W'($urandom));
        end
        if (t > 2047) t = 2047;
        if (t < -2048) t = -2048;
        return t;
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Control inactive after reset: field extremes, tick extremes.
        send_call(12'sd2047, 32'h0000_0000);
        send_call(-12'sd2048, 32'hFFFF_FFFF);

        // Cooling, no dwell: climb one stage per call up to three, then back
        // down past each step-down threshold while the relays sequence.
        apply_settings(MODE_COOL, 6'd15, 8'd1, 8'd2, 8'd1, 16'd0);
        send_call(12'sd151, 32'd10);
        send_call(12'sd152, 32'd11);
        send_call(12'sd153, 32'd12);
        send_call(12'sd154, 32'd13);
        send_call(12'sd153, 32'd14);
        send_call(12'sd152, 32'd15);
        send_call(12'sd151, 32'd16);
        send_call(12'sd150, 32'd17);

        // Heating mirror image, with a deep demand far below the setpoint.
        apply_settings(MODE_HEAT, 6'd15, 8'd1, 8'd2, 8'd1, 16'd0);
        send_call(12'sd148, 32'd20);
        send_call(12'sd147, 32'd21);
        send_call(-12'sd1000, 32'd22);
        send_call(12'sd147, 32'd23);
        send_call(12'sd148, 32'd24);
        send_call(12'sd1500, 32'd25);

        // Mode three: active but neither direction, so the stage holds.
        apply_settings(MODE_HOLD, 6'd15, 8'd1, 8'd2, 8'd1, 16'd0);
        send_call(-12'sd1000, 32'd30);
        send_call(12'sd1500, 32'd31);

        // Longest dwell across the tick wrap.
        apply_settings(MODE_COOL, 6'd15, 8'd1, 8'd2, 8'd1, 16'hFFFF);
        send_call(12'sd1500, 32'hFFFF_0000);
        send_call(12'sd1500, 32'hFFFF_FFF0);
        send_call(12'sd1500, 32'h0000_FF00);
        send_call(12'sd1500, 32'h0001_FF00);

        // Random phases: first the two extremes, one inactive phase and one
        // hold phase, then random settings. The final phase runs with no
        // idling on either side.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: apply_settings(MODE_COOL, 6'd63, 8'd255, 8'd255, 8'd255, 16'hFFFF);
                1: apply_settings(MODE_HEAT, 6'd0, 8'd0, 8'd0, 8'd0, 16'd0);
                2: apply_settings(MODE_OFF, 6'($urandom_range(0, 63)), pick_band(),
                                  pick_band(), pick_band(), pick_dwell());
                3: apply_settings(MODE_HOLD, 6'($urandom_range(0, 63)), pick_band(),
                                  pick_band(), pick_band(), pick_dwell());
                default: begin
                    case ($urandom_range(0, 7))
                        0:       apply_settings(MODE_OFF, 6'($urandom_range(0, 63)),
                                                pick_band(), pick_band(), pick_band(),
                                                pick_dwell());
                        1, 2, 3: apply_settings(MODE_HEAT, 6'($urandom_range(0, 63)),
                                                pick_band(), pick_band(), pick_band(),
                                                pick_dwell());
                        default: apply_settings(MODE_COOL, 6'($urandom_range(0, 63)),
                                                pick_band(), pick_band(), pick_band(),
                                                pick_dwell());
                    endcase
                end
            endcase
            quiet = (ph == PHASES - 1);
            stall_en = ($urandom_range(0, 3) != 0);
            gap_en = ($urandom_range(0, 3) != 0);
            temp_walk = cur_sp10;
            for (int n = 0; n < CALLS_PER_PHASE; n++) begin
                tick = next_tick(tick, cur_dwell);
                temp_walk = next_temp(temp_walk);
                send_call(TEMP_W'(temp_walk), tick);
            end
        end

        // Wait for the last results, let the pipeline go quiet, then judge.
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/fcsc_pkg.sv
design/fcsc_regs.sv
design/fcsc_hyst.sv
design/fcsc_seq.sv
design/fancoil_three_speed_controller.sv
bench/fancoil_speed_checker.sv
bench/fancoil_three_speed_controller_tb.sv
